// File: hdl/els_pkg.sv
// Shared types and constants for the LOOK elevator scheduler.
package els_pkg;

  localparam int NUM_FLOORS = 8;
  localparam int QDEPTH     = 8;
  localparam int FLOOR_W    = 3;
  localparam int CNT_W      = $clog2(QDEPTH + 1);
  localparam int LAMP_W     = 8;

  typedef logic [FLOOR_W-1:0] floor_t;
  typedef logic [CNT_W-1:0]   qcnt_t;

  typedef enum logic [1:0] {
    DIR_UP   = 2'd0,
    DIR_DOWN = 2'd1,
    DIR_WAIT = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_TICK    = 2'd1,
    OP_TOGGLE  = 2'd2
  } op_e;

  // Queue command: at most one of push / pop per cycle.
  typedef struct packed {
    logic   push;
    logic   pop;
    floor_t value;
  } qctl_t;

endpackage

// File: hdl/els_qcell.sv
// One slot of a sorted queue: compares against the insert value and shifts.
module els_qcell (
  input  logic            clk_i,
  input  els_pkg::qctl_t  ctl_i,       // push already gated for dup/full
  input  logic            desc_i,      // 1: descending order
  input  logic            valid_i,     // slot lies below the fill count
  input  els_pkg::floor_t prev_val_i,
  input  logic            prev_cond_i,
  input  els_pkg::floor_t next_val_i,
  output els_pkg::floor_t val_o,
  output logic            cond_o,      // insert point at or before this slot
  output logic            eq_o
);
  import els_pkg::*;

  floor_t val_q, val_d;

  always_comb begin
    if (!valid_i) begin
      cond_o = 1'b1;
    end else if (desc_i) begin
      cond_o = (val_q < ctl_i.value);
    end else begin
      cond_o = (val_q > ctl_i.value);
    end
  end

  assign eq_o  = valid_i && (val_q == ctl_i.value);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctl_i.push) begin
      if (prev_cond_i) begin
        val_d = prev_val_i;
      end else if (cond_o) begin
        val_d = ctl_i.value;
      end
    end else if (ctl_i.pop) begin
      val_d = next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// File: hdl/els_queue.sv
// Sorted duplicate-free floor queue built as a chain of compare-and-shift cells.
module els_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            desc_i,
  input  els_pkg::qctl_t  ctl_i,
  output els_pkg::floor_t head_o,
  output logic            empty_o
);
  import els_pkg::*;

  qcnt_t  cnt_q, cnt_d;
  floor_t vals     [QDEPTH];
  floor_t vals_ext [QDEPTH+1];
  floor_t nxt      [QDEPTH];
  logic [QDEPTH-1:0] cond;
  logic [QDEPTH:0]   cond_ext;
  logic [QDEPTH-1:0] eq;
  logic [QDEPTH-1:0] valid;
  logic   push_ok;
  qctl_t  cell_ctl;

  // Drop a push that duplicates a queued floor or finds the queue full.
  assign push_ok  = ctl_i.push && (eq == '0) && (cnt_q < qcnt_t'(QDEPTH));
  assign cell_ctl = '{push: push_ok, pop: ctl_i.pop && (cnt_q != '0), value: ctl_i.value};

  assign vals_ext[0] = '0;
  assign cond_ext[0] = 1'b0;

  for (genvar k = 0; k < QDEPTH; k++) begin : g_cell
    assign valid[k]      = (cnt_q > qcnt_t'(k));
    assign vals_ext[k+1] = vals[k];
    assign cond_ext[k+1] = cond[k];
    if (k < QDEPTH - 1) begin : g_mid
      assign nxt[k] = vals[k+1];
    end else begin : g_last
      assign nxt[k] = vals[k];
    end

    els_qcell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (cell_ctl),
      .desc_i      (desc_i),
      .valid_i     (valid[k]),
      .prev_val_i  (vals_ext[k]),
      .prev_cond_i (cond_ext[k]),
      .next_val_i  (nxt[k]),
      .val_o       (vals[k]),
      .cond_o      (cond[k]),
      .eq_o        (eq[k])
    );
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cell_ctl.push) begin
      cnt_d = cnt_q + qcnt_t'(1);
    end else if (cell_ctl.pop) begin
      cnt_d = cnt_q - qcnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign head_o  = vals[0];
  assign empty_o = (cnt_q == '0);

endmodule

// File: hdl/elevator_look_scheduler_core.sv
// Top level of the LOOK elevator scheduler: event decode, car state, two floor queues.
//
// Usage:
//   Slave stream carries one event per transaction: tuser is the opcode
//   (request, motion tick, emergency toggle), tdata carries the floor.
//   Master stream returns exactly one status transaction per event: car
//   floor, target floor, direction, halt flag, lamp mask, arrival flag.
//   Status is registered and appears in the cycle after the event is accepted.
//   Throughput: one event per cycle while the receiver takes each status;
//   the pending-floor queues are chains of compare-and-shift cells
//   that insert or pop as each event is accepted.
//   Stall: the status register holds while m_axis_tready_i is low; a new
//   event is taken in the same cycle the held status leaves, so the
//   input is stalled only while a status waits and the receiver is stalled.
//   Reset (rst_ni low, asynchronous): car at floor 0, goal 0, waiting,
//   no emergency, queues empty, lamps dark, no status pending.
//   Queue slot contents are not reset; only slots below the fill count
//   are ever read.
module elevator_look_scheduler_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [2:0] floor, [7:3] zero
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // [2:0] car_floor, [5:3] target_floor,
                                        // [7:6] direction, [8] halted,
                                        // [16:9] lamp_mask, [17] arrived, [23:18] zero
);
  import els_pkg::*;

  // Car state
  floor_t            car_q, car_d;
  floor_t            goal_q, goal_d;
  dir_e              dir_q, dir_d;
  dir_e              saved_q, saved_d;
  logic              stop_q, stop_d;
  logic [LAMP_W-1:0] lamps_q, lamps_d;
  logic              arrived;

  // Status output register
  logic        out_vld_q;
  logic [23:0] out_data_q;

  logic   accept;
  op_e    op;
  floor_t req_floor;
  qctl_t  up_ctl, dn_ctl;
  floor_t up_head, dn_head;
  logic   up_empty, dn_empty;

  assign s_axis_tready_o = !out_vld_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign op              = op_e'(s_axis_tuser_i);
  assign req_floor       = s_axis_tdata_i[FLOOR_W-1:0];

  // Event decode: next car state and queue commands.
  always_comb begin
    car_d   = car_q;
    goal_d  = goal_q;
    dir_d   = dir_q;
    saved_d = saved_q;
    stop_d  = stop_q;
    lamps_d = lamps_q;
    arrived = 1'b0;
    up_ctl  = '{push: 1'b0, pop: 1'b0, value: req_floor};
    dn_ctl  = '{push: 1'b0, pop: 1'b0, value: req_floor};

    if (accept) begin
      case (op)
        OP_REQUEST: begin
          if ((int'(req_floor) < NUM_FLOORS) && (req_floor != car_q)) begin
            lamps_d[req_floor] = 1'b1;
            if (dir_q == DIR_UP) begin
              if (req_floor < car_q) begin
                dn_ctl.push = 1'b1;
              end else if (req_floor > goal_q) begin
                up_ctl.push = 1'b1;
              end else if (req_floor < goal_q) begin
                // nearer on the way: old goal goes back to the queue
                up_ctl.push  = 1'b1;
                up_ctl.value = goal_q;
                goal_d       = req_floor;
              end
            end else if (dir_q == DIR_DOWN) begin
              if (req_floor > car_q) begin
                up_ctl.push = 1'b1;
              end else if (req_floor < goal_q) begin
                dn_ctl.push = 1'b1;
              end else if (req_floor > goal_q) begin
                dn_ctl.push  = 1'b1;
                dn_ctl.value = goal_q;
                goal_d       = req_floor;
              end
            end else begin
              // waiting (also during emergency): take it as the goal
              goal_d = req_floor;
              dir_d  = (req_floor > car_q) ? DIR_UP : DIR_DOWN;
            end
          end
        end
        OP_TICK: begin
          if ((dir_q == DIR_UP) || (dir_q == DIR_DOWN)) begin
            if (car_q != goal_q) begin
              car_d = (goal_q > car_q) ? car_q + floor_t'(1) : car_q - floor_t'(1);
            end else begin
              arrived          = 1'b1;
              lamps_d[car_q]   = 1'b0;
              if (up_empty && dn_empty) begin
                dir_d = DIR_WAIT;
              end else if (dir_q == DIR_UP) begin
                if (up_empty) begin
                  dir_d      = DIR_DOWN;
                  goal_d     = dn_head;
                  dn_ctl.pop = 1'b1;
                end else begin
                  goal_d     = up_head;
                  up_ctl.pop = 1'b1;
                end
              end else begin
                if (dn_empty) begin
                  dir_d      = DIR_UP;
                  goal_d     = up_head;
                  up_ctl.pop = 1'b1;
                end else begin
                  goal_d     = dn_head;
                  dn_ctl.pop = 1'b1;
                end
              end
            end
          end
        end
        OP_TOGGLE: begin
          if (stop_q) begin
            stop_d = 1'b0;
            dir_d  = saved_q;
          end else begin
            stop_d  = 1'b1;
            saved_d = dir_q;
            dir_d   = DIR_WAIT;
          end
        end
        default: begin
          // unused opcode: status only
        end
      endcase
    end
  end

  els_queue u_up_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .desc_i  (1'b0),
    .ctl_i   (up_ctl),
    .head_o  (up_head),
    .empty_o (up_empty)
  );

  els_queue u_dn_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .desc_i  (1'b1),
    .ctl_i   (dn_ctl),
    .head_o  (dn_head),
    .empty_o (dn_empty)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      car_q     <= '0;
      goal_q    <= '0;
      dir_q     <= DIR_WAIT;
      saved_q   <= DIR_WAIT;
      stop_q    <= 1'b0;
      lamps_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      car_q   <= car_d;
      goal_q  <= goal_d;
      dir_q   <= dir_d;
      saved_q <= saved_d;
      stop_q  <= stop_d;
      lamps_q <= lamps_d;
      if (accept) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Status payload, loaded with each accepted event.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {6'b0, arrived, lamps_d, stop_d, dir_d, goal_d, car_d};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
